// ===== hdl/fdcc_pkg.sv =====
`default_nettype none

package fdcc_pkg;

	localparam int HEADER_BYTES_DEF    = 20;
	localparam int PREV_OFFSET_DEF     = 16;
	localparam int MAX_FRAME_BYTES_DEF = 256;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CRC_EN     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EXP_VER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NULL_ADDR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 3'd4;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_SHORT   = 3'd1,
		ST_CRC     = 3'd2,
		ST_VERSION = 3'd3,
		ST_ADDR    = 3'd4,
		ST_LONG    = 3'd5
	} status_t;

	typedef struct packed {
		logic        crc_check_enable;
		logic [3:0]  expected_version;
		logic [31:0] null_address;
		logic [31:0] broadcast_address;
		logic        big_endian_fields;
	} cfg_t;

	// CRC-16/CCITT-FALSE, one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [31:0] pack4(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic big_endian);
		return big_endian ? {b0, b1, b2, b3} : {b3, b2, b1, b0};
	endfunction

	function automatic logic [15:0] pack2(input logic [7:0] b0, input logic [7:0] b1,
			input logic big_endian);
		return big_endian ? {b0, b1} : {b1, b0};
	endfunction

endpackage

`default_nettype wire

// ===== hdl/fdcc_cfg_regs.sv =====
`default_nettype none

module fdcc_cfg_regs
	import fdcc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.crc_check_enable  <= 1'b1;
			cfg_q.expected_version  <= 4'd1;
			cfg_q.null_address      <= 32'h0000_0000;
			cfg_q.broadcast_address <= 32'hFFFF_FFFF;
			cfg_q.big_endian_fields <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CRC_EN:     cfg_q.crc_check_enable  <= cfg_data[0];
				CFG_EXP_VER:    cfg_q.expected_version  <= cfg_data[3:0];
				CFG_NULL_ADDR:  cfg_q.null_address      <= cfg_data[31:0];
				CFG_BCAST_ADDR: cfg_q.broadcast_address <= cfg_data[31:0];
				CFG_BIG_ENDIAN: cfg_q.big_endian_fields <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/frame_deframe_crc_check.sv =====
`default_nettype none

// Frame receiver: takes one frame byte per request, last_byte set on the final
// byte, and returns one status/header request, registered from the final byte.
// A byte is taken every unstalled cycle; the CRC-16/CCITT-FALSE update of one
// byte per cycle sets that rate. Non-final bytes are taken even while a
// result waits at the output; a final byte waits until the output register is
// free. The last two bytes are the CRC trailer. No clearing pass after reset.
module frame_deframe_crc_check
	import fdcc_pkg::*;
#(
	parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
	parameter int PREV_OFFSET     = PREV_OFFSET_DEF,
	parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [7:0]            in_byte,
	input  wire logic                  last_byte,

	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [2:0]                 status,
	output logic [3:0]                 version,
	output logic [3:0]                 frame_type,
	output logic [7:0]                 flag_bits,
	output logic [31:0]                src_addr,
	output logic [31:0]                dst_addr,
	output logic [15:0]                seq_num,
	output logic [15:0]                network_id,
	output logic [7:0]                 hops_left,
	output logic [7:0]                 security_byte,
	output logic [31:0]                prev_hop,
	output logic [7:0]                 payload_length
);

	localparam int CNT_W  = $clog2(MAX_FRAME_BYTES + 2);
	localparam int HIDX_W = $clog2(HEADER_BYTES);
	localparam int LEN_W  = (CNT_W > 9) ? CNT_W : 9;

	cfg_t cfg;

	fdcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	logic [15:0]      crc_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      tail_q;
	logic             ovf_q;
	logic [7:0]       hdr_q [HEADER_BYTES];

	logic out_valid_q;
	status_t status_q;
	logic [3:0]  version_q, frame_type_q;
	logic [7:0]  flag_bits_q, hops_left_q, security_byte_q, payload_length_q;
	logic [31:0] src_addr_q, dst_addr_q, prev_hop_q;
	logic [15:0] seq_num_q, network_id_q;

	logic in_acc, acc_last;
	assign in_stall = out_valid_q && out_stall && last_byte;
	assign in_acc   = in_valid && !in_stall;
	assign acc_last = in_acc && last_byte;

	// next frame state
	logic [15:0]      crc_n, tail_n;
	logic [CNT_W-1:0] cnt_n;
	logic             ovf_n;

	always_comb begin
		crc_n  = (cnt_q >= CNT_W'(2)) ? crc16_byte(crc_q, tail_q[15:8]) : crc_q;
		tail_n = {tail_q[7:0], in_byte};
		cnt_n  = (cnt_q <= CNT_W'(MAX_FRAME_BYTES)) ? cnt_q + CNT_W'(1) : cnt_q;
		ovf_n  = ovf_q || (cnt_n > CNT_W'(MAX_FRAME_BYTES));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			cnt_q  <= '0;
			tail_q <= '0;
			ovf_q  <= 1'b0;
		end else if (in_acc) begin
			if (last_byte) begin
				crc_q  <= CRC_INIT;
				cnt_q  <= '0;
				tail_q <= '0;
				ovf_q  <= 1'b0;
			end else begin
				crc_q  <= crc_n;
				cnt_q  <= cnt_n;
				tail_q <= tail_n;
				ovf_q  <= ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (cnt_q < CNT_W'(HEADER_BYTES))) begin
			hdr_q[cnt_q[HIDX_W-1:0]] <= in_byte;
		end
	end

	// previous-hop bytes past the header read as zero
	logic [7:0] prev_b [4];
	for (genvar i = 0; i < 4; i++) begin : g_prev
		if (PREV_OFFSET + i < HEADER_BYTES) begin : g_in
			assign prev_b[i] = hdr_q[PREV_OFFSET + i];
		end else begin : g_out
			assign prev_b[i] = 8'h00;
		end
	end

	// result of the frame ending with this byte
	logic [LEN_W-1:0] len, plen_full;
	logic [15:0]      trailer;
	logic [31:0]      src_c, dst_c;
	logic             short_c;
	status_t          status_c;
	logic [7:0]       plen_c;

	always_comb begin
		len       = LEN_W'(cnt_n);
		short_c   = len < LEN_W'(HEADER_BYTES + 2);
		plen_full = len - LEN_W'(HEADER_BYTES + 2);
		plen_c    = (plen_full > LEN_W'(255)) ? 8'hFF : plen_full[7:0];
		trailer   = pack2(tail_n[15:8], tail_n[7:0], cfg.big_endian_fields);
		src_c     = pack4(hdr_q[2], hdr_q[3], hdr_q[4], hdr_q[5], cfg.big_endian_fields);
		dst_c     = pack4(hdr_q[6], hdr_q[7], hdr_q[8], hdr_q[9], cfg.big_endian_fields);
		if (short_c) begin
			status_c = ST_SHORT;
		end else if (ovf_n) begin
			status_c = ST_LONG;
			plen_c   = 8'h00;
		end else if (cfg.crc_check_enable && (crc_n != trailer)) begin
			status_c = ST_CRC;
		end else if (hdr_q[0][7:4] != cfg.expected_version) begin
			status_c = ST_VERSION;
		end else if ((src_c == cfg.null_address) || (src_c == cfg.broadcast_address) ||
				(dst_c == cfg.null_address)) begin
			status_c = ST_ADDR;
		end else begin
			status_c = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (acc_last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_last) begin
			status_q <= status_c;
			if (short_c) begin
				version_q        <= '0;
				frame_type_q     <= '0;
				flag_bits_q      <= '0;
				src_addr_q       <= '0;
				dst_addr_q       <= '0;
				seq_num_q        <= '0;
				network_id_q     <= '0;
				hops_left_q      <= '0;
				security_byte_q  <= '0;
				prev_hop_q       <= '0;
				payload_length_q <= '0;
			end else begin
				version_q        <= hdr_q[0][7:4];
				frame_type_q     <= hdr_q[0][3:0];
				flag_bits_q      <= hdr_q[1];
				src_addr_q       <= src_c;
				dst_addr_q       <= dst_c;
				seq_num_q        <= pack2(hdr_q[10], hdr_q[11], cfg.big_endian_fields);
				network_id_q     <= pack2(hdr_q[12], hdr_q[13], cfg.big_endian_fields);
				hops_left_q      <= hdr_q[14];
				security_byte_q  <= hdr_q[15];
				prev_hop_q       <= pack4(prev_b[0], prev_b[1], prev_b[2], prev_b[3],
						cfg.big_endian_fields);
				payload_length_q <= plen_c;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign version        = version_q;
	assign frame_type     = frame_type_q;
	assign flag_bits      = flag_bits_q;
	assign src_addr       = src_addr_q;
	assign dst_addr       = dst_addr_q;
	assign seq_num        = seq_num_q;
	assign network_id     = network_id_q;
	assign hops_left      = hops_left_q;
	assign security_byte  = security_byte_q;
	assign prev_hop       = prev_hop_q;
	assign payload_length = payload_length_q;

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_last |=> out_valid_q)
		else $error("final byte did not produce a result");

	a_last_clears_frame: assert property (@(posedge clk) disable iff (!arst_n)
		acc_last |=> (cnt_q == '0) && (crc_q == CRC_INIT) && !ovf_q)
		else $error("frame state not cleared after final byte");

	a_count_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_FRAME_BYTES + 1))
		else $error("byte count past saturation");

	a_short_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_SHORT)) |->
			(src_addr_q == '0) && (prev_hop_q == '0) && (payload_length_q == '0))
		else $error("short frame result carries nonzero fields");

	a_long_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (status_q == ST_LONG)) |-> (payload_length_q == '0))
		else $error("long frame result carries a payload length");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
	import fdcc_pkg::*;

	localparam int HDR_LEN      = HEADER_BYTES_DEF;
	localparam int PREV_POS     = PREV_OFFSET_DEF;
	localparam int MAX_LEN      = MAX_FRAME_BYTES_DEF;
	localparam int MIN_LEN      = HDR_LEN + 2;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_BYTES = 170;

	typedef struct packed {
		status_t     status;
		logic [3:0]  version;
		logic [3:0]  frame_type;
		logic [7:0]  flag_bits;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] seq_num;
		logic [15:0] network_id;
		logic [7:0]  hops_left;
		logic [7:0]  security_byte;
		logic [31:0] prev_hop;
		logic [7:0]  payload_length;
	} frame_result_t;

	typedef struct packed {
		logic [3:0]  ver;
		logic [3:0]  ftype;
		logic [7:0]  flags;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] seq;
		logic [15:0] net;
		logic [7:0]  hops;
		logic [7:0]  sec;
		logic [31:0] prev;
	} hdr_fields_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic [7:0]            in_byte   = 8'h00;
	logic                  last_byte = 1'b0;
	logic                  out_stall = 1'b0;

	logic        in_stall;
	logic        out_valid;
	logic [2:0]  status;
	logic [3:0]  version;
	logic [3:0]  frame_type;
	logic [7:0]  flag_bits;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic [15:0] seq_num;
	logic [15:0] network_id;
	logic [7:0]  hops_left;
	logic [7:0]  security_byte;
	logic [31:0] prev_hop;
	logic [7:0]  payload_length;

	frame_deframe_crc_check i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_byte        (in_byte),
		.last_byte      (last_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.version        (version),
		.frame_type     (frame_type),
		.flag_bits      (flag_bits),
		.src_addr       (src_addr),
		.dst_addr       (dst_addr),
		.seq_num        (seq_num),
		.network_id     (network_id),
		.hops_left      (hops_left),
		.security_byte  (security_byte),
		.prev_hop       (prev_hop),
		.payload_length (payload_length)
	);

	// shadow configuration
	logic        cfg_crc_en  = 1'b1;
	logic [3:0]  cfg_exp_ver = 4'd1;
	logic [31:0] cfg_null    = 32'h0000_0000;
	logic [31:0] cfg_bcast   = 32'hFFFF_FFFF;
	logic        cfg_big     = 1'b0;

	// frame predictor state
	logic [15:0] pred_crc      = CRC_INIT;
	logic [8:0]  pred_count    = '0;
	logic [15:0] pred_tail     = '0;
	logic [7:0]  pred_hdr [HDR_LEN];
	logic        pred_overflow = 1'b0;

	frame_result_t expected_frames [$];
	frame_result_t oldest;
	logic [7:0]    frame_bytes [$];

	int  errors         = 0;
	int  cycles         = 0;
	int  bytes_sent     = 0;
	int  frames_sent    = 0;
	int  results_seen   = 0;
	int  config_changes = 0;
	bit  idle_on        = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			out_stall <= idle_on && ($urandom_range(99) < 11);
		end
	end

	function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		repeat (8) begin
			c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [31:0] hdr_word32(input int idx);
		if (cfg_big) begin
			return {pred_hdr[idx], pred_hdr[idx+1], pred_hdr[idx+2], pred_hdr[idx+3]};
		end
		return {pred_hdr[idx+3], pred_hdr[idx+2], pred_hdr[idx+1], pred_hdr[idx]};
	endfunction

	function automatic logic [15:0] hdr_word16(input int idx);
		return cfg_big ? {pred_hdr[idx], pred_hdr[idx+1]} : {pred_hdr[idx+1], pred_hdr[idx]};
	endfunction

	task automatic frame_model_step(input logic [7:0] b, input logic l);
		frame_result_t r;
		logic [15:0]   trailer;
		int            len;
		int            plen;
		if (pred_count >= 2) pred_crc = crc16_next(pred_crc, pred_tail[15:8]);
		pred_tail = {pred_tail[7:0], b};
		if (pred_count < HDR_LEN) pred_hdr[pred_count] = b;
		if (pred_count <= MAX_LEN) pred_count = pred_count + 1'b1;
		if (pred_count > MAX_LEN) pred_overflow = 1'b1;
		if (l) begin
			r = '0;
			len = pred_count;
			if (len < MIN_LEN) begin
				r.status = ST_SHORT;
			end else begin
				trailer = cfg_big ? pred_tail : {pred_tail[7:0], pred_tail[15:8]};
				plen = len - MIN_LEN;
				if (plen > 255) plen = 255;
				r.version       = pred_hdr[0][7:4];
				r.frame_type    = pred_hdr[0][3:0];
				r.flag_bits     = pred_hdr[1];
				r.src_addr      = hdr_word32(2);
				r.dst_addr      = hdr_word32(6);
				r.seq_num       = hdr_word16(10);
				r.network_id    = hdr_word16(12);
				r.hops_left     = pred_hdr[14];
				r.security_byte = pred_hdr[15];
				r.prev_hop      = hdr_word32(PREV_POS);
				r.payload_length = plen[7:0];
				if (pred_overflow) begin
					r.status = ST_LONG;
					r.payload_length = 8'd0;
				end else if (cfg_crc_en && pred_crc != trailer) begin
					r.status = ST_CRC;
				end else if (r.version != cfg_exp_ver) begin
					r.status = ST_VERSION;
				end else if (r.src_addr == cfg_null || r.src_addr == cfg_bcast ||
						r.dst_addr == cfg_null) begin
					r.status = ST_ADDR;
				end else begin
					r.status = ST_OK;
				end
			end
			expected_frames.push_back(r);
			pred_crc      = CRC_INIT;
			pred_count    = '0;
			pred_tail     = '0;
			pred_overflow = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 40) $display("mismatch at cycle %0d: %s", cycles, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_frames.size() == 0) begin
				report_mismatch("result with no frame outstanding");
			end else begin
				oldest = expected_frames.pop_front();
				check_field("status", 32'(status), 32'(oldest.status));
				check_field("version", 32'(version), 32'(oldest.version));
				check_field("frame_type", 32'(frame_type), 32'(oldest.frame_type));
				check_field("flag_bits", 32'(flag_bits), 32'(oldest.flag_bits));
				check_field("src_addr", src_addr, oldest.src_addr);
				check_field("dst_addr", dst_addr, oldest.dst_addr);
				check_field("seq_num", 32'(seq_num), 32'(oldest.seq_num));
				check_field("network_id", 32'(network_id), 32'(oldest.network_id));
				check_field("hops_left", 32'(hops_left), 32'(oldest.hops_left));
				check_field("security_byte", 32'(security_byte), 32'(oldest.security_byte));
				check_field("prev_hop", prev_hop, oldest.prev_hop);
				check_field("payload_length", 32'(payload_length),
					32'(oldest.payload_length));
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic l);
		while (idle_on && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		in_byte   <= b;
		last_byte <= l;
		do @(posedge clk); while (in_stall);
		frame_model_step(b, l);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		frames_sent++;
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(negedge clk);
	endtask

	task automatic apply_config(input logic en, input logic [3:0] ver, input logic [31:0] nul,
			input logic [31:0] bc, input logic big);
		wait_results_done();
		write_reg(CFG_CRC_EN, {31'd0, en});
		write_reg(CFG_EXP_VER, {28'd0, ver});
		write_reg(CFG_NULL_ADDR, nul);
		write_reg(CFG_BCAST_ADDR, bc);
		write_reg(CFG_BIG_ENDIAN, {31'd0, big});
		cfg_we      <= 1'b0;
		cfg_crc_en  = en;
		cfg_exp_ver = ver;
		cfg_null    = nul;
		cfg_bcast   = bc;
		cfg_big     = big;
		config_changes++;
	endtask

	task automatic put_field(input logic [31:0] v, input int n);
		for (int i = 0; i < n; i++) begin
			frame_bytes.push_back(cfg_big ? v[8*(n-1-i) +: 8] : v[8*i +: 8]);
		end
	endtask

	task automatic build_frame(input hdr_fields_t h, input int plen, input bit bad_crc);
		logic [15:0] crc;
		frame_bytes.delete();
		frame_bytes.push_back({h.ver, h.ftype});
		frame_bytes.push_back(h.flags);
		put_field(h.src, 4);
		put_field(h.dst, 4);
		put_field({16'd0, h.seq}, 2);
		put_field({16'd0, h.net}, 2);
		frame_bytes.push_back(h.hops);
		frame_bytes.push_back(h.sec);
		put_field(h.prev, 4);
		repeat (plen) frame_bytes.push_back(8'($urandom_range(255)));
		crc = CRC_INIT;
		foreach (frame_bytes[i]) crc = crc16_next(crc, frame_bytes[i]);
		if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(15));
		if (cfg_big) begin
			frame_bytes.push_back(crc[15:8]);
			frame_bytes.push_back(crc[7:0]);
		end else begin
			frame_bytes.push_back(crc[7:0]);
			frame_bytes.push_back(crc[15:8]);
		end
	endtask

	task automatic build_raw(input int n);
		frame_bytes.delete();
		repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
	endtask

	function automatic logic [31:0] open_address(input bit as_src);
		logic [31:0] a;
		do a = $urandom; while (a == cfg_null || (as_src && a == cfg_bcast));
		return a;
	endfunction

	function automatic hdr_fields_t good_fields();
		hdr_fields_t h;
		h.ver   = cfg_exp_ver;
		h.ftype = 4'($urandom_range(15));
		h.flags = 8'($urandom_range(255));
		h.src   = open_address(1'b1);
		h.dst   = open_address(1'b0);
		h.seq   = 16'($urandom_range(65535));
		h.net   = 16'($urandom_range(65535));
		h.hops  = 8'($urandom_range(255));
		h.sec   = 8'($urandom_range(255));
		h.prev  = $urandom;
		return h;
	endfunction

	function automatic logic [31:0] pick_address();
		case ($urandom_range(3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] pick_version();
		case ($urandom_range(3))
			0: return 4'd0;
			1: return 4'd15;
			default: return 4'($urandom_range(15));
		endcase
	endfunction

	task automatic test_default_config();
		hdr_fields_t h;
		h = good_fields();
		build_frame(h, 0, 1'b0);
		send_frame();
		build_frame(good_fields(), 7, 1'b0);
		send_frame();
		build_frame(good_fields(), 3, 1'b1);
		send_frame();
		h = good_fields();
		h.ver = 4'd0;
		build_frame(h, 2, 1'b0);
		send_frame();
		// all-zero and all-one headers
		h = '0;
		h.ver = 4'd1;
		build_frame(h, 1, 1'b0);
		send_frame();
		h = '1;
		h.ver = 4'd1;
		build_frame(h, 1, 1'b0);
		send_frame();
	endtask

	task automatic test_short_frames();
		build_raw(1);
		send_frame();
		build_raw(2);
		send_frame();
		build_raw(MIN_LEN - 1);
		send_frame();
		build_frame(good_fields(), 0, 1'b0);
		void'(frame_bytes.pop_back());
		send_frame();
	endtask

	task automatic test_size_limits();
		// long run with no idling on either side
		idle_on = 1'b0;
		build_frame(good_fields(), MAX_LEN - MIN_LEN, 1'b0);
		send_frame();
		build_frame(good_fields(), MAX_LEN - MIN_LEN + 1, 1'b0);
		send_frame();
		build_frame(good_fields(), MAX_LEN - MIN_LEN + 1, 1'b1);
		send_frame();
		build_raw(MAX_LEN + 4);
		send_frame();
		idle_on = 1'b1;
	endtask

	task automatic test_check_priority();
		hdr_fields_t h;
		apply_config(1'b0, 4'd1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		build_frame(good_fields(), 4, 1'b1);
		send_frame();
		h = good_fields();
		h.ver = 4'd9;
		build_frame(h, 4, 1'b1);
		send_frame();
		h.src = cfg_null;
		build_frame(h, 0, 1'b0);
		send_frame();
		h = good_fields();
		h.dst = cfg_null;
		build_frame(h, 2, 1'b1);
		send_frame();
		apply_config(1'b1, 4'd1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
		h = good_fields();
		h.ver = 4'd3;
		h.src = cfg_null;
		build_frame(h, 2, 1'b1);
		send_frame();
	endtask

	task automatic test_address_rules();
		hdr_fields_t h;
		apply_config(1'b1, 4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
		build_frame(good_fields(), 5, 1'b0);
		send_frame();
		h = good_fields();
		h.src = cfg_null;
		build_frame(h, 0, 1'b0);
		send_frame();
		h = good_fields();
		h.src = cfg_bcast;
		build_frame(h, 0, 1'b0);
		send_frame();
		h = good_fields();
		h.dst = cfg_null;
		build_frame(h, 0, 1'b0);
		send_frame();
		h = good_fields();
		h.dst = cfg_bcast;
		build_frame(h, 0, 1'b0);
		send_frame();
		apply_config(1'b1, 4'd0, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 1'b0);
		build_frame(good_fields(), 3, 1'b0);
		send_frame();
		h = good_fields();
		h.src = cfg_bcast;
		build_frame(h, 1, 1'b0);
		send_frame();
		h = good_fields();
		h.dst = cfg_bcast;
		build_frame(h, 1, 1'b0);
		send_frame();
	endtask

	task automatic test_random_traffic();
		hdr_fields_t h;
		logic [3:0]  delta;
		int          start_bytes;
		int          frame_no;
		int          kind;
		int          plen;
		start_bytes = bytes_sent;
		frame_no = 0;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			if (frame_no % 3 == 2) begin
				apply_config(1'($urandom_range(1)), pick_version(), pick_address(),
					pick_address(), 1'($urandom_range(1)));
			end
			h = good_fields();
			kind = $urandom_range(99);
			if (kind < 6) begin
				delta = 4'($urandom_range(1, 15));
				h.ver = cfg_exp_ver ^ delta;
			end else if (kind < 9) begin
				h.src = cfg_null;
			end else if (kind < 12) begin
				h.src = cfg_bcast;
			end else if (kind < 15) begin
				h.dst = cfg_null;
			end
			plen = ($urandom_range(19) == 0) ? $urandom_range(MAX_LEN - MIN_LEN) : $urandom_range(24);
			kind = $urandom_range(99);
			if (kind < 8) begin
				build_raw($urandom_range(1, MIN_LEN - 1));
			end else if (kind < 10) begin
				build_raw($urandom_range(MAX_LEN + 1, MAX_LEN + 12));
			end else begin
				build_frame(h, plen, kind < 20);
				if (kind >= 20 && kind < 26) begin
					plen = $urandom_range(1, frame_bytes.size() - 1);
					while (frame_bytes.size() > plen) void'(frame_bytes.pop_back());
				end
			end
			send_frame();
			if ($urandom_range(9) == 0) wait_results_done();
			frame_no++;
		end
	endtask

	initial begin
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_config();
		test_short_frames();
		test_size_limits();
		test_check_priority();
		test_address_rules();
		test_random_traffic();
		wait_results_done();
		repeat (8) @(negedge clk);
		$display("covered %0d frames (%0d bytes), %0d results compared, %0d register settings",
			frames_sent, bytes_sent, results_seen, config_changes);
		$display("directed: defaults, short and oversize frames, check order, address rules");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
